// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, cell encoding, operation codes, controller states and
// the structs that pass between the cursor unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Field widths fixed by the channel definitions
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(COLUMNS + 1);

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [CHAR_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [2*CHAR_W-1:0] cell_t;

  // Character codes and attribute
  localparam byte_t NEWLINE    = 8'd10;
  localparam byte_t BLANK_CHAR = 8'h20;
  localparam byte_t TEXT_ATTR  = 8'h07;
  localparam byte_t ZERO_BYTE  = 8'h00;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  // Cursor unit results: store write, next cursor, read lookup
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    cell_t wr_data;
    row_t  next_row;
    col_t  next_col;
    logic  scrolled;
    row_t  cur_row;
    col_t  cur_col;
    addr_t rd_addr;
    logic  rd_in_range;
    logic  rd_hit;
  } cur_res_t;

endpackage

`default_nettype wire

// File: design/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: request and response channels of the text console writer
// Valid/ready channels; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [tcw_pkg::CHAR_W-1:0] character;
  logic [tcw_pkg::ROW_W-1:0]  read_row;
  logic [tcw_pkg::COL_W-1:0]  read_col;

  modport source (output valid, op, character, read_row, read_col, input ready);
  modport sink   (input valid, op, character, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CHAR_W-1:0] cell_char;
  logic [tcw_pkg::CHAR_W-1:0] cell_attr;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic                       scrolled;

  modport source (output valid, cell_char, cell_attr, cursor_row, cursor_col, scrolled,
                  input ready);
  modport sink   (input valid, cell_char, cell_attr, cursor_row, cursor_col, scrolled,
                  output ready);
endinterface

`default_nettype wire

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cell store and cursor
// Prints bytes at a cursor (newline, wrap, scroll up) and reads back cells.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   req_i    in   valid/ready        op, character, read_row, read_col
//   rsp_o    out  valid/ready        cell_char, cell_attr, cursor_row,
//                                    cursor_col, scrolled
//
// A put completes at the accepting edge: the store write and cursor update
// happen there and the result word is loaded into the output register.
// A read passes through the registered store read port before its result
// word is loaded; no new word is taken while the read is in flight.
// Reset clears cursor, row base and per-row fill counts at once; the store
// itself needs no clearing pass, since cells beyond a row's fill count read
// as blanks. A scroll moves no cells: it rotates the row base and zeroes one fill count.
// A word is taken only when the output register is empty or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcw_req_if.sink   req_i,
  tcw_rsp_if.source rsp_o
);

  tcw_pkg::state_e   state_q, state_d;
  tcw_pkg::cur_res_t cur;
  tcw_pkg::cell_t    ram_rdata;

  logic accept, is_read, load_put, load_read, ram_re, out_free;
  logic rd_in_range_q, rd_hit_q;

  logic           out_valid_q, out_valid_d;
  tcw_pkg::byte_t out_char_q, out_attr_q, out_char_d, out_attr_d;
  tcw_pkg::row_t  out_row_q, out_row_d;
  tcw_pkg::col_t  out_col_q, out_col_d;
  logic           out_scr_q, out_scr_d;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign is_read  = (tcw_pkg::op_e'(req_i.op) == tcw_pkg::OP_READ);
  assign accept   = req_i.valid && req_i.ready;

  // Cursor, row mapping and fill counts
  tcw_cursor u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .put_i      (accept && !is_read),
    .char_i     (req_i.character),
    .read_row_i (req_i.read_row),
    .read_col_i (req_i.read_col),
    .res_o      (cur)
  );

  // Cell store
  tcw_screen_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (cur.wr_en),
    .waddr_i (cur.wr_addr),
    .wdata_i (cur.wr_data),
    .re_i    (ram_re),
    .raddr_i (cur.rd_addr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (accept && is_read) begin
          state_d = tcw_pkg::ST_READ;
        end
      end
      tcw_pkg::ST_READ: begin
        state_d = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller outputs
  always_comb begin
    req_i.ready = 1'b0;
    ram_re      = 1'b0;
    load_put    = 1'b0;
    load_read   = 1'b0;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        req_i.ready = out_free;
        ram_re      = accept && is_read;
        load_put    = accept && !is_read;
      end
      tcw_pkg::ST_READ: begin
        // output register is free: it was empty or draining at acceptance
        load_read = 1'b1;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  // Result word
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_scr_d   = out_scr_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_put) begin
      out_valid_d = 1'b1;
      out_char_d  = tcw_pkg::ZERO_BYTE;
      out_attr_d  = tcw_pkg::ZERO_BYTE;
      out_row_d   = cur.next_row;
      out_col_d   = cur.next_col;
      out_scr_d   = cur.scrolled;
    end else if (load_read) begin
      out_valid_d = 1'b1;
      if (!rd_in_range_q) begin
        out_char_d = tcw_pkg::ZERO_BYTE;
        out_attr_d = tcw_pkg::ZERO_BYTE;
      end else if (rd_hit_q) begin
        out_char_d = ram_rdata[tcw_pkg::CHAR_W-1:0];
        out_attr_d = ram_rdata[2*tcw_pkg::CHAR_W-1:tcw_pkg::CHAR_W];
      end else begin
        // cell untouched since its row was blanked
        out_char_d = tcw_pkg::BLANK_CHAR;
        out_attr_d = tcw_pkg::TEXT_ATTR;
      end
      out_row_d = cur.cur_row;
      out_col_d = cur.cur_col;
      out_scr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: hold lookup flags for the read in flight
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rd_in_range_q <= cur.rd_in_range;
      rd_hit_q      <= cur.rd_hit;
    end
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_scr_q  <= out_scr_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cell_char  = out_char_q;
  assign rsp_o.cell_attr  = out_attr_q;
  assign rsp_o.cursor_row = out_row_q;
  assign rsp_o.cursor_col = out_col_q;
  assign rsp_o.scrolled   = out_scr_q;

  // The read state is always followed by idle in the next cycle
  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_READ |=> state_q == tcw_pkg::ST_IDLE)
    else $error("read state held longer than one cycle");

  // Read data lands in an output register that is free, and no word is taken meanwhile
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_READ |-> (!out_valid_q || rsp_o.ready) && !req_i.ready)
    else $error("read result would overwrite a pending word");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur.cur_row < tcw_pkg::row_t'(tcw_pkg::ROWS)
    && cur.cur_col < tcw_pkg::col_t'(tcw_pkg::COLUMNS))
    else $error("cursor off screen");

  // A scroll parks the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_put && cur.scrolled |=> out_row_q == tcw_pkg::row_t'(tcw_pkg::ROWS - 1)
    && out_col_q == '0 && out_scr_q)
    else $error("scroll left cursor misplaced");

endmodule

`default_nettype wire

// File: design/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram: screen cell store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire tcw_pkg::addr_t waddr_i,
  input  wire tcw_pkg::cell_t wdata_i,
  input  wire logic           re_i,
  input  wire tcw_pkg::addr_t raddr_i,
  output      tcw_pkg::cell_t rdata_o
);

  tcw_pkg::cell_t mem_q [tcw_pkg::CELLS];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor: cursor, rotating row base and per-row fill counts
// Maps logical rows onto store rows, computes the cursor step of a put and
// tells whether a stored cell has been written since its row was blanked.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             put_i,
  input  wire tcw_pkg::byte_t   char_i,
  input  wire tcw_pkg::row_t    read_row_i,
  input  wire tcw_pkg::col_t    read_col_i,
  output      tcw_pkg::cur_res_t res_o
);

  tcw_pkg::row_t line_q, line_d, base_q, base_d, cur_phys, rd_phys;
  tcw_pkg::col_t col_q, col_d;
  tcw_pkg::cnt_t fill_q [tcw_pkg::ROWS];
  logic [tcw_pkg::COL_W:0] col_inc;
  logic [tcw_pkg::ROW_W:0] line_inc, cur_sum, rd_sum;
  logic newline, wrap, advance, scroll, in_range;

  always_comb begin
    newline  = (char_i == tcw_pkg::NEWLINE);
    col_inc  = {1'b0, col_q} + 1'b1;
    wrap     = (col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));
    advance  = newline || wrap;
    line_inc = {1'b0, line_q} + 1'b1;
    scroll   = advance && (line_inc >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));

    // logical row -> store row
    cur_sum  = {1'b0, line_q} + {1'b0, base_q};
    cur_phys = (cur_sum >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS))
             ? tcw_pkg::row_t'(cur_sum - (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS))
             : cur_sum[tcw_pkg::ROW_W-1:0];
    rd_sum   = {1'b0, read_row_i} + {1'b0, base_q};
    rd_phys  = (rd_sum >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS))
             ? tcw_pkg::row_t'(rd_sum - (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS))
             : rd_sum[tcw_pkg::ROW_W-1:0];

    if (scroll) begin
      line_d = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
      col_d  = '0;
    end else if (advance) begin
      line_d = line_inc[tcw_pkg::ROW_W-1:0];
      col_d  = '0;
    end else begin
      line_d = line_q;
      col_d  = col_inc[tcw_pkg::COL_W-1:0];
    end

    // rotate the base: the old top row becomes the blank bottom row
    if (scroll) begin
      base_d = (base_q == tcw_pkg::row_t'(tcw_pkg::ROWS - 1)) ? '0 : base_q + 1'b1;
    end else begin
      base_d = base_q;
    end

    in_range = (read_row_i < tcw_pkg::row_t'(tcw_pkg::ROWS))
            && (read_col_i < tcw_pkg::col_t'(tcw_pkg::COLUMNS));

    res_o.wr_en       = put_i && !newline;
    res_o.wr_addr     = tcw_pkg::addr_t'(cur_phys) * tcw_pkg::addr_t'(tcw_pkg::COLUMNS)
                      + tcw_pkg::addr_t'(col_q);
    res_o.wr_data     = {tcw_pkg::TEXT_ATTR, char_i};
    res_o.next_row    = line_d;
    res_o.next_col    = col_d;
    res_o.scrolled    = scroll;
    res_o.cur_row     = line_q;
    res_o.cur_col     = col_q;
    res_o.rd_addr     = tcw_pkg::addr_t'(rd_phys) * tcw_pkg::addr_t'(tcw_pkg::COLUMNS)
                      + tcw_pkg::addr_t'(read_col_i);
    res_o.rd_in_range = in_range;
    res_o.rd_hit      = in_range && (tcw_pkg::cnt_t'(read_col_i) < fill_q[rd_phys]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      col_q  <= '0;
      base_q <= '0;
      for (int r = 0; r < tcw_pkg::ROWS; r++) begin
        fill_q[r] <= '0;
      end
    end else if (put_i) begin
      line_q <= line_d;
      col_q  <= col_d;
      base_q <= base_d;
      // cells of a row are written left to right from column 0;
      // the row blanked by a scroll drops its count
      for (int r = 0; r < tcw_pkg::ROWS; r++) begin
        if (scroll && (tcw_pkg::row_t'(r) == base_q)) begin
          fill_q[r] <= '0;
        end else if (!newline && (tcw_pkg::row_t'(r) == cur_phys)) begin
          fill_q[r] <= tcw_pkg::cnt_t'(col_inc);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: test/tcw_screen_checker.sv
// ----------------------------------------------------------------------------
// tcw_screen_checker: screen and cursor predictor for the text console writer
// Mirrors the cell store and cursor from accepted request words, queues the
// expected response words and compares each accepted response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_checker
  import tcw_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tcw_req_if          req_i,
  tcw_rsp_if          rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    byte_t cell_char;
    byte_t cell_attr;
    row_t  cursor_row;
    col_t  cursor_col;
    logic  scrolled;
  } console_word_t;

  localparam cell_t BLANK_CELL = {TEXT_ATTR, BLANK_CHAR};

  cell_t         screen_img [CELLS];
  int unsigned   cur_line;
  int unsigned   cur_column;
  console_word_t expected_q [$];

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    fail_count_o++;
    $display("%0t tcw check: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      screen_img[i] = screen_img[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen_img[i] = BLANK_CELL;
    end
    cur_line   = ROWS - 1;
    cur_column = 0;
  endtask

  task automatic predict_word();
    console_word_t w;
    int unsigned   idx;
    w = '0;
    if (op_e'(req_i.op) == OP_READ) begin
      if (req_i.read_row < ROWS && req_i.read_col < COLUMNS) begin
        idx = req_i.read_row * COLUMNS + req_i.read_col;
        w.cell_char = screen_img[idx][CHAR_W-1:0];
        w.cell_attr = screen_img[idx][2*CHAR_W-1:CHAR_W];
      end
    end else begin
      if (req_i.character == NEWLINE) begin
        cur_column = 0;
        cur_line++;
      end else begin
        screen_img[cur_line * COLUMNS + cur_column] = {TEXT_ATTR, req_i.character};
        cur_column++;
        if (cur_column >= COLUMNS) begin
          cur_column = 0;
          cur_line++;
        end
      end
      if (cur_line >= ROWS) begin
        scroll_screen();
        w.scrolled = 1'b1;
      end
    end
    w.cursor_row = row_t'(cur_line);
    w.cursor_col = col_t'(cur_column);
    expected_q.push_back(w);
  endtask

  task automatic check_word();
    console_word_t w;
    if (expected_q.size() == 0) begin
      flag_mismatch("response word with none pending", 1, 0);
      return;
    end
    w = expected_q.pop_front();
    if (rsp_i.cell_char !== w.cell_char)
      flag_mismatch("cell_char", 32'(rsp_i.cell_char), 32'(w.cell_char));
    if (rsp_i.cell_attr !== w.cell_attr)
      flag_mismatch("cell_attr", 32'(rsp_i.cell_attr), 32'(w.cell_attr));
    if (rsp_i.cursor_row !== w.cursor_row)
      flag_mismatch("cursor_row", 32'(rsp_i.cursor_row), 32'(w.cursor_row));
    if (rsp_i.cursor_col !== w.cursor_col)
      flag_mismatch("cursor_col", 32'(rsp_i.cursor_col), 32'(w.cursor_col));
    if (rsp_i.scrolled !== w.scrolled)
      flag_mismatch("scrolled", 32'(rsp_i.scrolled), 32'(w.scrolled));
  endtask

  // compare before predicting, so a response never pairs with the word
  // accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        screen_img[i] = BLANK_CELL;
      end
      cur_line     = 0;
      cur_column   = 0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) check_word();
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) predict_word();
      pending_o = expected_q.size();
    end
  end

endmodule

`default_nettype wire

// File: test/text_console_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_tb: stimulus and verdict for the text console writer
// Drives put and read words through the request channel under varying
// backpressure; the screen checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int          PERIOD     = 8;
  localparam int          ITEMS      = 1100;
  localparam int          DRAIN_CYC  = 16;
  localparam int unsigned TIME_LIMIT = 4_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned words_sent;
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned fail_count;
  int unsigned pending;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_writer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  tcw_screen_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // Response side: stall at random at the current rate, change only on
  // the falling edge so the block sees a settled ready at the rising edge.
  always @(negedge clk_i) begin
    rsp_ch.ready = ($urandom_range(99) >= rsp_stall_pct);
  end

  // Hard stop in case the block hangs or loses a word.
  initial begin
    #(TIME_LIMIT);
    $display("text_console_writer: mismatch");
    $finish;
  end

  // Pick the idle rates from how far the run has come: the sender idles
  // lightly while the receiver stalls hard, then the reverse, then neither.
  function automatic void pick_idle_rates();
    if (words_sent < ITEMS / 3) begin
      send_idle_pct = 25;
      rsp_stall_pct = 82;
    end else if (words_sent < 2 * ITEMS / 3) begin
      send_idle_pct = 82;
      rsp_stall_pct = 25;
    end else begin
      send_idle_pct = 0;
      rsp_stall_pct = 0;
    end
  endfunction

  // Offer one word, starting and ending at a falling edge. While idle,
  // drop valid and scramble the payload so the block must ignore it.
  task automatic send_word(input op_e op, input byte_t ch, input row_t rr,
                           input col_t rc);
    pick_idle_rates();
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid     = 1'b0;
      req_ch.op        = 1'($urandom_range(1));
      req_ch.character = byte_t'($urandom_range(255));
      req_ch.read_row  = row_t'($urandom_range(31));
      req_ch.read_col  = col_t'($urandom_range(127));
      @(negedge clk_i);
    end
    req_ch.valid     = 1'b1;
    req_ch.op        = op;
    req_ch.character = ch;
    req_ch.read_row  = rr;
    req_ch.read_col  = rc;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_char(input byte_t ch);
    send_word(OP_PUT, ch, row_t'($urandom_range(31)), col_t'($urandom_range(127)));
  endtask

  task automatic read_cell(input row_t rr, input col_t rc);
    send_word(OP_READ, byte_t'($urandom_range(255)), rr, rc);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned run_len;
    int unsigned pick;

    // hold every input at a known value from time zero
    words_sent       = 0;
    send_idle_pct    = 25;
    rsp_stall_pct    = 82;
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_PUT;
    req_ch.character = ZERO_BYTE;
    req_ch.read_row  = '0;
    req_ch.read_col  = '0;
    rsp_ch.ready     = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: blank cells after reset at both corners, reads off the
    // screen on each axis, extreme bytes, a newline, then read them back.
    read_cell(row_t'(0), col_t'(0));
    read_cell(row_t'(ROWS - 1), col_t'(COLUMNS - 1));
    read_cell(row_t'(31), col_t'(0));
    read_cell(row_t'(0), col_t'(127));
    read_cell(row_t'(ROWS), col_t'(COLUMNS));
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(NEWLINE);
    put_char(8'h7E);
    read_cell(row_t'(0), col_t'(0));
    read_cell(row_t'(0), col_t'(1));
    read_cell(row_t'(0), col_t'(2));
    read_cell(row_t'(0), col_t'(3));
    read_cell(row_t'(1), col_t'(0));
    put_char(NEWLINE);

    // Random: mostly text runs and newlines that fill the screen, wrap
    // lines and scroll it, mixed with bursts of reads and some noise.
    while (words_sent < ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        // a full line, one short of it, or a short or long run
        pick = $urandom_range(9);
        if (pick < 2)      run_len = COLUMNS;
        else if (pick < 4) run_len = COLUMNS - 1;
        else if (pick < 8) run_len = $urandom_range(12, 1);
        else               run_len = $urandom_range(COLUMNS + 10, 1);
        repeat (run_len) put_char(byte_t'($urandom_range(255)));
        if ($urandom_range(1) == 1) put_char(NEWLINE);
      end else if (kind < 45) begin
        repeat ($urandom_range(4, 1)) put_char(NEWLINE);
      end else if (kind < 90) begin
        repeat ($urandom_range(12, 1)) begin
          pick = $urandom_range(3);
          if (pick < 2) begin
            read_cell(row_t'($urandom_range(ROWS - 1)), col_t'($urandom_range(COLUMNS - 1)));
          end else if (pick == 2) begin
            // the bottom rows hold the freshest text after a scroll
            read_cell(row_t'($urandom_range(ROWS - 1, ROWS - 2)),
                      col_t'($urandom_range(15)));
          end else begin
            read_cell(row_t'($urandom_range(31)), col_t'($urandom_range(127)));
          end
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_word(op_e'($urandom_range(1)), byte_t'($urandom_range(255)),
                    row_t'($urandom_range(31)), col_t'($urandom_range(127)));
        end
      end
    end
    req_ch.valid = 1'b0;

    // wait for every expected response, then drain for strays
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("text_console_writer: match");
    end else begin
      $display("text_console_writer: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_screen_ram.sv
design/tcw_cursor.sv
design/text_console_writer.sv
test/tcw_screen_checker.sv
test/text_console_writer_tb.sv
